// ===== design/json_keyed_object_extractor_assert.svh =====
// assertion macros used by the extractor top level
`ifndef JSON_KEYED_OBJECT_EXTRACTOR_ASSERT_SVH
`define JSON_KEYED_OBJECT_EXTRACTOR_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define JKOE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("jkoe assertion failed");

// antecedent in one cycle implies consequent in the next
`define JKOE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jkoe assertion failed");

`endif

// ===== design/jkoe_pkg.sv =====
// shared types and constants of the json keyed object extractor
package jkoe_pkg;

  // scan phases
  localparam logic [2:0] PH_SEEK_KEY   = 3'd0;
  localparam logic [2:0] PH_SEEK_COLON = 3'd1;
  localparam logic [2:0] PH_SEEK_BRACE = 3'd2;
  localparam logic [2:0] PH_STREAM     = 3'd3;
  localparam logic [2:0] PH_DONE       = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OBJECT    = 2'd0;
  localparam logic [1:0] ST_NO_KEY    = 2'd1;
  localparam logic [1:0] ST_UNTERM    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_LENGTH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW    = 2'd1;
  localparam logic [1:0] CFG_KEY_HIGH   = 2'd2;

  // special characters
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // work entry passed from front to back: an optional byte result
  // followed by an optional end-of-payload report
  typedef struct packed {
    logic       has_a;
    logic [7:0] a_byte;
    logic [1:0] a_status;
    logic       a_last;
    logic       has_b;
    logic [1:0] b_status;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [2:0] phase;
  } front_stat_t;

endpackage

// ===== design/jkoe_front.sv =====
// front end: accepts payload bytes, matches the key and tracks the object
module jkoe_front #(
  parameter int KEY_MAX   = 16,
  parameter int NEST_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 payload_last_i,
  input  logic [4:0]           key_length_i,
  input  logic [63:0]          key_low_i,
  input  logic [63:0]          key_high_i,
  input  jkoe_pkg::fifo_stat_t fifo_stat_i,
  output logic                 push_o,
  output jkoe_pkg::entry_t     entry_o,
  output jkoe_pkg::front_stat_t stat_o
);

  localparam int HistDepth = KEY_MAX + 2;
  localparam int IW = $clog2(HistDepth);
  localparam logic [4:0] KeyMaxL = 5'(KEY_MAX);

  logic [7:0]           hist_q [HistDepth-1];
  logic [7:0]           hist_d [HistDepth-1];
  logic [7:0]           recent [HistDepth];
  logic [7:0]           key_ch [KEY_MAX];
  logic [127:0]         key_all;
  logic [4:0]           key_n;
  logic                 key_hit;
  logic                 accept;

  logic [2:0]           phase_q, phase_d;
  logic [NEST_BITS-1:0] nest_q, nest_d;
  logic                 str_q, str_d;
  logic                 esc_q, esc_d;

  logic                 do_stream;
  logic [NEST_BITS-1:0] s_nest, n_dec;
  jkoe_pkg::entry_t     ent;

  assign in_ready_o   = ~fifo_stat_i.full;
  assign accept       = in_valid_i & in_ready_o;
  assign stat_o.phase = phase_q;

  // newest byte first, then the stored history
  always_comb begin
    recent[0] = in_byte_i;
    for (int k = 1; k < HistDepth; k++) begin
      recent[k] = hist_q[k-1];
    end
  end

  assign key_all = {key_high_i, key_low_i};
  always_comb begin
    for (int i = 0; i < KEY_MAX; i++) begin
      key_ch[i] = key_all[8*i +: 8];
    end
  end

  assign key_n = (key_length_i > KeyMaxL) ? KeyMaxL : key_length_i;

  // quoted key ends at the newest byte
  always_comb begin
    key_hit = (recent[0] == jkoe_pkg::CH_QUOTE) &&
              (recent[IW'(6'(key_n) + 6'd1)] == jkoe_pkg::CH_QUOTE);
    for (int i = 0; i < KEY_MAX; i++) begin
      if (5'(i) < key_n) begin
        if (recent[IW'(6'(key_n) - 6'(i))] != key_ch[i]) begin
          key_hit = 1'b0;
        end
      end
    end
  end

  assign do_stream = (phase_q == jkoe_pkg::PH_STREAM) ||
                     ((phase_q == jkoe_pkg::PH_SEEK_BRACE) && (in_byte_i == jkoe_pkg::CH_OPEN));
  assign s_nest    = (phase_q == jkoe_pkg::PH_STREAM) ? nest_q : '0;
  assign n_dec     = (s_nest != '0) ? s_nest - 1'b1 : s_nest;

  always_comb begin
    phase_d      = phase_q;
    nest_d       = nest_q;
    str_d        = str_q;
    esc_d        = esc_q;
    ent.has_a    = 1'b0;
    ent.a_byte   = in_byte_i;
    ent.a_status = jkoe_pkg::ST_OBJECT;
    ent.a_last   = 1'b0;
    ent.has_b    = 1'b0;
    ent.b_status = jkoe_pkg::ST_NO_KEY;

    unique case (phase_q)
      jkoe_pkg::PH_SEEK_KEY: begin
        if (key_hit) begin
          phase_d = jkoe_pkg::PH_SEEK_COLON;
        end
      end
      jkoe_pkg::PH_SEEK_COLON: begin
        if (in_byte_i == jkoe_pkg::CH_COLON) begin
          phase_d = jkoe_pkg::PH_SEEK_BRACE;
        end
      end
      default: ;
    endcase

    if (do_stream) begin
      phase_d   = jkoe_pkg::PH_STREAM;
      nest_d    = s_nest;
      str_d     = (phase_q == jkoe_pkg::PH_STREAM) ? str_q : 1'b0;
      esc_d     = 1'b0;
      ent.has_a = 1'b1;
      priority if ((phase_q == jkoe_pkg::PH_STREAM) && esc_q) begin
        esc_d = 1'b0;
      end else if (in_byte_i == jkoe_pkg::CH_BSLASH) begin
        esc_d = 1'b1;
      end else if (in_byte_i == jkoe_pkg::CH_QUOTE) begin
        str_d = ~str_d;
      end else if (str_d) begin
        str_d = 1'b1;
      end else if (in_byte_i == jkoe_pkg::CH_OPEN) begin
        if (&s_nest) begin
          ent.a_byte   = 8'd0;
          ent.a_status = jkoe_pkg::ST_OVERFLOW;
          ent.a_last   = 1'b1;
          phase_d      = jkoe_pkg::PH_DONE;
        end else begin
          nest_d = s_nest + 1'b1;
        end
      end else if (in_byte_i == jkoe_pkg::CH_CLOSE) begin
        nest_d = n_dec;
        if (n_dec == '0) begin
          ent.a_last = 1'b1;
          phase_d    = jkoe_pkg::PH_DONE;
        end
      end else begin
        esc_d = 1'b0;
      end
    end

    // end of payload: report and clear
    if (payload_last_i) begin
      if (phase_d != jkoe_pkg::PH_DONE) begin
        ent.has_b    = 1'b1;
        ent.b_status = (phase_d == jkoe_pkg::PH_STREAM) ? jkoe_pkg::ST_UNTERM
                                                        : jkoe_pkg::ST_NO_KEY;
      end
      phase_d = jkoe_pkg::PH_SEEK_KEY;
      nest_d  = '0;
      str_d   = 1'b0;
      esc_d   = 1'b0;
    end
  end

  always_comb begin
    hist_d[0] = payload_last_i ? 8'd0 : in_byte_i;
    for (int k = 1; k < HistDepth - 1; k++) begin
      hist_d[k] = payload_last_i ? 8'd0 : hist_q[k-1];
    end
  end

  assign push_o  = accept & (ent.has_a | ent.has_b);
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HistDepth - 1; k++) begin
        hist_q[k] <= 8'd0;
      end
      phase_q <= jkoe_pkg::PH_SEEK_KEY;
      nest_q  <= '0;
      str_q   <= 1'b0;
      esc_q   <= 1'b0;
    end else if (accept) begin
      hist_q  <= hist_d;
      phase_q <= phase_d;
      nest_q  <= nest_d;
      str_q   <= str_d;
      esc_q   <= esc_d;
    end
  end

endmodule

// ===== design/jkoe_fifo.sv =====
// small work queue between front and back
module jkoe_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jkoe_pkg::entry_t     data_i,
  input  logic                 pop_i,
  output jkoe_pkg::entry_t     data_o,
  output jkoe_pkg::fifo_stat_t stat_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  jkoe_pkg::entry_t mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == Full);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign data_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/jkoe_back.sv =====
// back end: turns queued entries into output transactions
module jkoe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jkoe_pkg::entry_t     entry_i,
  input  jkoe_pkg::fifo_stat_t fifo_stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic [1:0]           status_o,
  output logic                 last_o
);

  jkoe_pkg::entry_t cur_q;
  logic             valid_q, valid_d;
  logic             a_pend_q, a_pend_d;
  logic             fire, final_one, advance;

  assign out_valid_o = valid_q;
  assign out_byte_o  = a_pend_q ? cur_q.a_byte : 8'd0;
  assign status_o    = a_pend_q ? cur_q.a_status : cur_q.b_status;
  assign last_o      = a_pend_q ? cur_q.a_last : 1'b1;

  assign fire      = valid_q & out_ready_i;
  assign final_one = ~(a_pend_q & cur_q.has_b);
  assign advance   = ~valid_q | (fire & final_one);
  assign pop_o     = advance & ~fifo_stat_i.empty;

  always_comb begin
    valid_d  = valid_q;
    a_pend_d = a_pend_q;
    if (advance) begin
      valid_d  = ~fifo_stat_i.empty;
      a_pend_d = entry_i.has_a;
    end else if (fire) begin
      a_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      a_pend_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      a_pend_q <= a_pend_d;
    end
  end

endmodule

// ===== design/json_keyed_object_extractor.sv =====
// top level of the json keyed object extractor
//
// usage: payload bytes enter on the in channel (in_byte_i, payload_last_i)
// one per transaction; payload_last_i marks the final byte of a payload.
// the block finds the first quoted key equal to the programmed key, then the
// next colon and the next opening brace, and streams that object's bytes on
// the out channel, last_o high on the matching closing brace. at payload end
// a missing key (status 1) or an unterminated object (status 2) is reported
// as one extra transaction with last_o high; brace depth overflow (status 3)
// replaces the offending byte and ends the object.
// the key is written on the cfg channel (index 0 length, 1 chars 0..7,
// 2 chars 8..15) while no payload is in flight; cfg_ready_o is always high.
// throughput: one byte accepted per cycle while the queue has room, set by the
// combinational key compare and brace tracker in the front end. each result
// passes the queue and then the output register before out_valid_o rises. the
// output stage delivers one result per cycle while the receiver is ready, a
// byte that causes two results occupies it for both; a QUEUE_DEPTH entry queue
// absorbs that and any receiver stall, and in_ready_o drops when it is full.
// reset: key length 1, key chars zero, history cleared, searching for key.
module json_keyed_object_extractor #(
  parameter int KEY_MAX     = 16,
  parameter int NEST_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // payload input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        payload_last_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  status_o,
  output logic        last_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

`include "json_keyed_object_extractor_assert.svh"

  // key registers
  logic [4:0]  key_length_q;
  logic [63:0] key_low_q;
  logic [63:0] key_high_q;

  // front to queue to back
  logic                  push, pop;
  jkoe_pkg::entry_t      push_entry, pop_entry;
  jkoe_pkg::fifo_stat_t  fifo_stat;
  jkoe_pkg::front_stat_t front_stat;

  // payload end taken while an object or key is still pending
  logic                  end_accept;

  assign cfg_ready_o = 1'b1;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= 5'd1;
      key_low_q    <= '0;
      key_high_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        jkoe_pkg::CFG_KEY_LENGTH: key_length_q <= cfg_data_i[4:0];
        jkoe_pkg::CFG_KEY_LOW:    key_low_q    <= cfg_data_i;
        jkoe_pkg::CFG_KEY_HIGH:   key_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // key match and object tracking, one byte per cycle while the queue has room
  jkoe_front #(
    .KEY_MAX   (KEY_MAX),
    .NEST_BITS (NEST_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .payload_last_i (payload_last_i),
    .key_length_i   (key_length_q),
    .key_low_i      (key_low_q),
    .key_high_i     (key_high_q),
    .fifo_stat_i    (fifo_stat),
    .push_o         (push),
    .entry_o        (push_entry),
    .stat_o         (front_stat)
  );

  // decouples the front from output stalls
  jkoe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .pop_i  (pop),
    .data_o (pop_entry),
    .stat_o (fifo_stat)
  );

  // output register, splits two-result entries
  jkoe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (pop_entry),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  assign end_accept = in_valid_i && in_ready_o && payload_last_i &&
                      (front_stat.phase != jkoe_pkg::PH_DONE);

  // queue status is consistent
  `JKOE_ASSERT(a_fifo_stat, !(fifo_stat.full && fifo_stat.empty))
  // a payload end outside the done phase always queues a result
  `JKOE_ASSERT_NEXT(a_end_report, end_accept, !fifo_stat.empty || out_valid_o)
  // an idle output stage picks up queued work next cycle
  `JKOE_ASSERT_NEXT(a_back_load, !fifo_stat.empty && !out_valid_o, out_valid_o)
  // error reports always close the transaction group
  `JKOE_ASSERT(a_err_last, !out_valid_o || (status_o == jkoe_pkg::ST_OBJECT) || last_o)

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the json keyed object extractor
module testbench;

  // must match the defaults of the block
  localparam int KEY_MAX    = 16;
  localparam int NEST_BITS  = 16;
  localparam int HIST_DEPTH = KEY_MAX + 2;
  localparam logic [NEST_BITS-1:0] NEST_MAX = '1;

  // one result transaction as seen on the out channel
  typedef struct packed {
    logic [7:0] obj_byte;
    logic [1:0] status;
    logic       lst;
  } obj_result_t;

  // one row of the directed table; rows with fixed set carry a typed
  // error report (byte 0, last 1) instead of the predicted results
  typedef struct packed {
    logic [7:0] in_b;
    logic       lst;
    logic       fixed;
    logic [1:0] status;
  } dir_row_t;

  // directed stimulus, run with the reset key: one zero character
  localparam dir_row_t DIRECTED [25] = '{
    // lone extreme byte right after reset, nothing to find
    '{8'hFF,               1'b1, 1'b1, jkoe_pkg::ST_NO_KEY},
    // key token cut by a payload boundary never matches
    '{jkoe_pkg::CH_QUOTE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{8'h00,               1'b1, 1'b1, jkoe_pkg::ST_NO_KEY},
    '{jkoe_pkg::CH_QUOTE,  1'b1, 1'b1, jkoe_pkg::ST_NO_KEY},
    // key found but no colon, so the brace is not taken
    '{jkoe_pkg::CH_QUOTE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{8'h00,               1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_QUOTE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_OPEN,   1'b1, 1'b1, jkoe_pkg::ST_NO_KEY},
    // opening brace on the final byte: streamed, then unterminated
    '{jkoe_pkg::CH_QUOTE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{8'h00,               1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_QUOTE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_COLON,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_OPEN,   1'b1, 1'b0, jkoe_pkg::ST_OBJECT},
    // escaped and quoted braces do not count, byte after the object ignored
    '{jkoe_pkg::CH_QUOTE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{8'h00,               1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_QUOTE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_COLON,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_OPEN,   1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_BSLASH, 1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_CLOSE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_QUOTE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_OPEN,   1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_QUOTE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{jkoe_pkg::CH_CLOSE,  1'b0, 1'b0, jkoe_pkg::ST_OBJECT},
    '{8'hFF,               1'b1, 1'b0, jkoe_pkg::ST_OBJECT}
  };

  // harmless filler for generated payloads: no braces, quotes or backslash
  string filler_chars = "0123456789abcdefxyz ,:[]tnul-+.eE";

  // clock, reset and block ports; the driven ones are known from time zero
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i      = 8'h00;
  logic        payload_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  out_byte_o;
  logic [1:0]  status_o;
  logic        last_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = jkoe_pkg::CFG_KEY_LENGTH;
  logic [63:0] cfg_data_i     = 64'h0;

  // predictor copy of the key registers
  logic [4:0]  k_len = 5'd1;
  logic [63:0] k_lo  = 64'h0;
  logic [63:0] k_hi  = 64'h0;

  // predictor copy of the per-payload scan state
  logic [7:0]           hist [HIST_DEPTH];
  logic [2:0]           p_phase = jkoe_pkg::PH_SEEK_KEY;
  logic [NEST_BITS-1:0] p_nest  = '0;
  logic                 p_in_str = 1'b0;
  logic                 p_esc    = 1'b0;

  // results of the byte just scanned, and all results still owed by the block
  obj_result_t step_results [$];
  obj_result_t awaited_results [$];

  logic [7:0]  pay_q [$];     // payload being built
  int          burst_left = 0;
  int          scanned_cnt = 0; // bytes the block had to look at
  int          fail_cnt = 0;
  obj_result_t mon_want;

  // receiver stall pattern state
  int   rx_left = 0;
  int   rx_mode = 0;
  logic [1:0] rx_tick = 2'd0;

  json_keyed_object_extractor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .payload_last_i (payload_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // payload state goes back to its reset values at every payload end
  task automatic clear_scan();
    int i;
    for (i = 0; i < HIST_DEPTH; i++) hist[i] = 8'h00;
    p_phase  = jkoe_pkg::PH_SEEK_KEY;
    p_nest   = '0;
    p_in_str = 1'b0;
    p_esc    = 1'b0;
  endtask

  function automatic logic [7:0] key_byte(int i);
    if (i < 8) return k_lo[8*i +: 8];
    return k_hi[8*(i-8) +: 8];
  endfunction

  function automatic int key_span();
    return (k_len > KEY_MAX) ? KEY_MAX : int'(k_len);
  endfunction

  // true when the newest bytes are the quoted key, newest byte last quote
  function automatic logic token_at_head();
    int n;
    int i;
    n = key_span();
    if (hist[0] != jkoe_pkg::CH_QUOTE || hist[n+1] != jkoe_pkg::CH_QUOTE) return 1'b0;
    for (i = 0; i < n; i++)
      if (hist[n-i] != key_byte(i)) return 1'b0;
    return 1'b1;
  endfunction

  task automatic note(input logic [7:0] b, input logic [1:0] st, input logic lst);
    obj_result_t r;
    r.obj_byte = b;
    r.status   = st;
    r.lst      = lst;
    step_results.push_back(r);
  endtask

  // one byte of the object: escapes first, then strings, then braces
  task automatic track_object_byte(input logic [7:0] b);
    if (p_esc) begin
      p_esc = 1'b0;
      note(b, jkoe_pkg::ST_OBJECT, 1'b0);
    end else if (b == jkoe_pkg::CH_BSLASH) begin
      p_esc = 1'b1;
      note(b, jkoe_pkg::ST_OBJECT, 1'b0);
    end else if (b == jkoe_pkg::CH_QUOTE) begin
      p_in_str = !p_in_str;
      note(b, jkoe_pkg::ST_OBJECT, 1'b0);
    end else if (p_in_str) begin
      note(b, jkoe_pkg::ST_OBJECT, 1'b0);
    end else if (b == jkoe_pkg::CH_OPEN) begin
      // depth counter full: the brace turns into an overflow report
      if (p_nest == NEST_MAX) begin
        note(8'h00, jkoe_pkg::ST_OVERFLOW, 1'b1);
        p_phase = jkoe_pkg::PH_DONE;
      end else begin
        p_nest++;
        note(b, jkoe_pkg::ST_OBJECT, 1'b0);
      end
    end else if (b == jkoe_pkg::CH_CLOSE) begin
      if (p_nest != 0) p_nest--;
      if (p_nest == 0) begin
        note(b, jkoe_pkg::ST_OBJECT, 1'b1);
        p_phase = jkoe_pkg::PH_DONE;
      end else begin
        note(b, jkoe_pkg::ST_OBJECT, 1'b0);
      end
    end else begin
      note(b, jkoe_pkg::ST_OBJECT, 1'b0);
    end
  endtask

  // expected results of one accepted byte, left in step_results
  task automatic predict_scan(input logic [7:0] b, input logic lst);
    int i;
    step_results.delete();
    for (i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = b;
    case (p_phase)
      jkoe_pkg::PH_SEEK_KEY: begin
        if (token_at_head()) p_phase = jkoe_pkg::PH_SEEK_COLON;
      end
      jkoe_pkg::PH_SEEK_COLON: begin
        if (b == jkoe_pkg::CH_COLON) p_phase = jkoe_pkg::PH_SEEK_BRACE;
      end
      jkoe_pkg::PH_SEEK_BRACE: begin
        if (b == jkoe_pkg::CH_OPEN) begin
          p_phase  = jkoe_pkg::PH_STREAM;
          p_nest   = '0;
          p_in_str = 1'b0;
          p_esc    = 1'b0;
          track_object_byte(b);
        end
      end
      jkoe_pkg::PH_STREAM: begin
        track_object_byte(b);
      end
      default: ;
    endcase
    if (lst) begin
      // missing colon or brace is reported like a missing key
      if (p_phase < jkoe_pkg::PH_STREAM) note(8'h00, jkoe_pkg::ST_NO_KEY, 1'b1);
      else if (p_phase == jkoe_pkg::PH_STREAM) note(8'h00, jkoe_pkg::ST_UNTERM, 1'b1);
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // one payload byte; the sender runs in bursts with random gaps between
  task automatic push_in_byte(input logic [7:0] b, input logic lst,
                              input logic fixed, input logic [1:0] st);
    int gap;
    int i;
    obj_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    in_byte_i      <= b;
    payload_last_i <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    // transaction accepted at this edge
    if (p_phase != jkoe_pkg::PH_DONE) scanned_cnt++;
    predict_scan(b, lst);
    if (fixed) begin
      r.obj_byte = 8'h00;
      r.status   = st;
      r.lst      = 1'b1;
      awaited_results.push_back(r);
    end else begin
      for (i = 0; i < step_results.size(); i++)
        awaited_results.push_back(step_results[i]);
    end
  endtask

  // stop sending and wait until every owed result is out, plus the
  // pipeline latency for trailing bytes that cause no result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // writes all three key registers back to back, only while idle
  task automatic load_key(input logic [4:0] len, input logic [63:0] lo,
                          input logic [63:0] hi);
    logic [63:0] word;
    logic [1:0]  idx;
    int          i;
    for (i = 0; i < 3; i++) begin
      case (i)
        0: begin
          idx  = jkoe_pkg::CFG_KEY_LENGTH;
          // upper bits of the length word are don't care, toggle them too
          word = {$urandom, $urandom};
          word[4:0] = len;
        end
        1: begin
          idx  = jkoe_pkg::CFG_KEY_LOW;
          word = lo;
        end
        default: begin
          idx  = jkoe_pkg::CFG_KEY_HIGH;
          word = hi;
        end
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= word;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx)
        jkoe_pkg::CFG_KEY_LENGTH: k_len = word[4:0];
        jkoe_pkg::CFG_KEY_LOW:    k_lo  = word;
        default:                  k_hi  = word;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // payload generation
  // ---------------------------------------------------------------------

  task automatic push_filler();
    pay_q.push_back(filler_chars[$urandom_range(0, filler_chars.len() - 1)]);
  endtask

  task automatic push_key_token();
    int i;
    pay_q.push_back(jkoe_pkg::CH_QUOTE);
    for (i = 0; i < key_span(); i++) pay_q.push_back(key_byte(i));
    pay_q.push_back(jkoe_pkg::CH_QUOTE);
  endtask

  // quoted string with escapes, high bytes and braces that must not count
  task automatic push_string();
    int m;
    int i;
    pay_q.push_back(jkoe_pkg::CH_QUOTE);
    m = $urandom_range(0, 6);
    for (i = 0; i < m; i++) begin
      case ($urandom_range(0, 4))
        0: begin
          pay_q.push_back(jkoe_pkg::CH_BSLASH);
          pay_q.push_back(8'($urandom));
        end
        1: pay_q.push_back(8'($urandom_range(128, 255)));
        2: pay_q.push_back(($urandom_range(0, 1) == 0) ? jkoe_pkg::CH_OPEN
                                                       : jkoe_pkg::CH_CLOSE);
        default: push_filler();
      endcase
    end
    pay_q.push_back(jkoe_pkg::CH_QUOTE);
  endtask

  // mostly well-formed "key": {object} payloads with random content; some
  // lack the colon, the brace or the closing brace, a few are pure noise
  task automatic build_payload();
    int kind;
    int n;
    int i;
    int d;
    pay_q.delete();
    kind = $urandom_range(0, 11);
    if (kind == 11) begin
      n = $urandom_range(1, 24);
      for (i = 0; i < n; i++) pay_q.push_back(8'($urandom));
      return;
    end
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) pay_q.push_back(8'($urandom));
      else push_filler();
    end
    push_key_token();
    if (kind == 10) return;                 // key only, nothing follows
    repeat ($urandom_range(0, 2)) pay_q.push_back(8'h20);
    if (kind != 9) pay_q.push_back(jkoe_pkg::CH_COLON); // missing colon otherwise
    repeat ($urandom_range(0, 2)) pay_q.push_back(8'h20);
    if (kind == 8) begin                    // missing brace
      push_filler();
      return;
    end
    pay_q.push_back(jkoe_pkg::CH_OPEN);
    if (kind == 7) return;                  // brace on the last byte
    d = 0;
    n = $urandom_range(0, 12);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          if (d < 4) begin
            pay_q.push_back(jkoe_pkg::CH_OPEN);
            d++;
          end
        end
        1: begin
          if (d > 0) begin
            pay_q.push_back(jkoe_pkg::CH_CLOSE);
            d--;
          end
        end
        2, 3: push_string();
        4: begin
          // escape outside a string
          pay_q.push_back(jkoe_pkg::CH_BSLASH);
          pay_q.push_back(8'($urandom));
        end
        5: pay_q.push_back(8'($urandom));
        default: push_filler();
      endcase
    end
    if (kind == 6) return;                  // unterminated object
    repeat (d) pay_q.push_back(jkoe_pkg::CH_CLOSE);
    pay_q.push_back(jkoe_pkg::CH_CLOSE);
    // trailing bytes, sometimes another copy of the key
    n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: pay_q.push_back(8'($urandom));
        1: push_key_token();
        default: push_filler();
      endcase
    end
  endtask

  task automatic send_payload();
    int i;
    for (i = 0; i < pay_q.size(); i++)
      push_in_byte(pay_q[i], i == pay_q.size() - 1, 1'b0, jkoe_pkg::ST_OBJECT);
  endtask

  // ---------------------------------------------------------------------
  // receiver: stall pattern switches, when a random countdown runs out, between always
  // ready, mostly ready, mostly stalled and a fixed one-in-four rhythm
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 2'd1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (rx_tick == 2'd0);
    endcase
  end

  // ---------------------------------------------------------------------
  // checker: every accepted result against the oldest owed one
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected transaction: out_byte %0h status %0d last %0b",
               out_byte_o, status_o, last_o);
        fail_cnt++;
      end else begin
        mon_want = awaited_results.pop_front();
        if (out_byte_o !== mon_want.obj_byte) begin
          $error("out_byte: expected %0h, got %0h", mon_want.obj_byte, out_byte_o);
          fail_cnt++;
        end
        if (status_o !== mon_want.status) begin
          $error("status: expected %0d, got %0d", mon_want.status, status_o);
          fail_cnt++;
        end
        if (last_o !== mon_want.lst) begin
          $error("last: expected %0b, got %0b", mon_want.lst, last_o);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int          i;
    int          s;
    int          target;
    logic [4:0]  len;
    logic [63:0] lo;
    logic [63:0] hi;

    clear_scan();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table with the reset key
    for (i = 0; i < 25; i++)
      push_in_byte(DIRECTED[i].in_b, DIRECTED[i].lst, DIRECTED[i].fixed,
                   DIRECTED[i].status);
    drain_results();

    // random payloads under a series of keys, extremes first
    for (s = 0; s < 8; s++) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (s)
        0: len = 5'd0;                              // empty key: two adjacent quotes
        1: begin                                    // longest key, all-ones characters
          len = 5'd16;
          lo  = '1;
          hi  = '1;
        end
        2: begin                                    // length beyond the maximum
          len = 5'd31;
          lo  = '0;
          hi  = '0;
        end
        3: len = 5'd1;
        4: len = 5'd17;
        default: len = 5'($urandom_range(2, 15));
      endcase
      load_key(len, lo, hi);
      target = scanned_cnt + 150;
      while (scanned_cnt < target) begin
        build_payload();
        send_payload();
      end
      drain_results();
    end

    if (fail_cnt == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== json_keyed_object_extractor.f =====
+incdir+design
design/jkoe_pkg.sv
design/jkoe_front.sv
design/jkoe_fifo.sv
design/jkoe_back.sv
design/json_keyed_object_extractor.sv
tb/testbench.sv
